>>> rtl/core/antialiased_line_stepper_unit_defines.svh
// ---------------------------------------------------------------------------
// Antialiased line stepper assertion macros
// Shared property forms for the checker of the line stepper.
// ---------------------------------------------------------------------------
`ifndef ANTIALIASED_LINE_STEPPER_UNIT_DEFINES_SVH
`define ANTIALIASED_LINE_STEPPER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define ALSU_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define ALSU_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/alsu_pkg.sv
// ---------------------------------------------------------------------------
// Antialiased line stepper package
// Shared types, codes and the arctangent cone table.
// ---------------------------------------------------------------------------
package alsu_pkg;

   localparam int SRC_BITS  = 13;
   localparam int CSR_ABITS = 5;
   localparam int CSR_DBITS = 32;

   localparam logic OP_START = 1'b0;
   localparam logic OP_STEP  = 1'b1;

   typedef enum logic [2:0] {
      REG_ROW_PITCH     = 3'd0,
      REG_ACTIVE_X      = 3'd1,
      REG_ACTIVE_Y      = 3'd2,
      REG_SOURCE_ENABLE = 3'd3,
      REG_SOURCE_XSHIFT = 3'd4,
      REG_SOURCE_YSHIFT = 3'd5,
      REG_SOURCE_WIDTH  = 3'd6,
      REG_SOURCE_HEIGHT = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic [12:0]        row_pitch;
      logic [11:0]        active_x_offset;
      logic [11:0]        active_y_offset;
      logic               source_enable;
      logic signed [11:0] source_x_shift;
      logic signed [11:0] source_y_shift;
      logic [12:0]        source_width;
      logic [12:0]        source_height;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_LEVEL,
      ST_SPLIT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load_line;
      logic div_step;
      logic level;
      logic split;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic steps_zero;
      logic div_last;
      logic out_free;
   } status_type;

   typedef logic [7:0] cone_rom_type [256];

   localparam real CONE_SCALE  = 128.0 / $atan(2.0);
   localparam real CONE_RECIP  = 0.015625;

   function automatic logic [7:0] cone_entry(input int k);
      int  m;
      int  f;
      real r;
      m = 127 - k;
      r = CONE_SCALE * $atan(((m < 0) ? -m : m) * CONE_RECIP);
      f = $rtoi(r);
      if (f > 127) begin
         f = 127;
      end
      return (m >= 0) ? 8'(128 - f) : 8'(128 + f);
   endfunction

   function automatic cone_rom_type build_cone();
      cone_rom_type t;
      for (int k = 0; k < 256; k++) begin
         t[k] = cone_entry(k);
      end
      return t;
   endfunction

   localparam cone_rom_type CONE_ROM = build_cone();

endpackage

>>> rtl/core/alsu_if.sv
// ---------------------------------------------------------------------------
// Antialiased line stepper channels
// Request and result channels with valid and ready.
// ---------------------------------------------------------------------------
interface alsu_req_if #(parameter int COORD_BITS = 12);
   logic                         valid;
   logic                         ready;
   logic                         operation;
   logic signed [COORD_BITS-1:0] start_x;
   logic signed [COORD_BITS-1:0] start_y;
   logic signed [COORD_BITS-1:0] end_x;
   logic signed [COORD_BITS-1:0] end_y;
   logic [15:0]                  line_color;

   modport source (output valid, operation, start_x, start_y, end_x, end_y, line_color,
                   input ready);
   modport sink (input valid, operation, start_x, start_y, end_x, end_y, line_color,
                 output ready);
endinterface

interface alsu_rsp_if #(parameter int ADDRESS_BITS = 22);
   logic                      valid;
   logic                      ready;
   logic [ADDRESS_BITS-1:0]   center_address;
   logic [7:0]                center_level;
   logic [ADDRESS_BITS-1:0]   plus_address;
   logic [7:0]                plus_level;
   logic [ADDRESS_BITS-1:0]   minus_address;
   logic [7:0]                minus_level;
   logic [15:0]               pixel_color;
   logic signed [12:0]        source_x;
   logic signed [12:0]        source_y;
   logic                      source_valid;
   logic                      last_step;

   modport source (output valid, center_address, center_level, plus_address, plus_level,
                   minus_address, minus_level, pixel_color, source_x, source_y,
                   source_valid, last_step, input ready);
   modport sink (input valid, center_address, center_level, plus_address, plus_level,
                 minus_address, minus_level, pixel_color, source_x, source_y,
                 source_valid, last_step, output ready);
endinterface

>>> rtl/core/alsu_csr.sv
// ---------------------------------------------------------------------------
// Antialiased line stepper registers
// Configuration register file behind a simple APB-style port.
// ---------------------------------------------------------------------------
module alsu_csr
   import alsu_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [CSR_ABITS-1:0] paddr,
   input  logic [CSR_DBITS-1:0] pwdata,
   output logic [CSR_DBITS-1:0] prdata,
   output logic                 pready,
   output cfg_type              cfg
);

   cfg_type       cfg_ff;
   reg_index_type idx;
   logic          wr;

   assign idx    = reg_index_type'(paddr[CSR_ABITS-1:2]);
   assign wr     = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff           <= '0;
         cfg_ff.row_pitch <= 13'd320;
      end else if (wr) begin
         case (idx)
            REG_ROW_PITCH:     cfg_ff.row_pitch       <= pwdata[12:0];
            REG_ACTIVE_X:      cfg_ff.active_x_offset <= pwdata[11:0];
            REG_ACTIVE_Y:      cfg_ff.active_y_offset <= pwdata[11:0];
            REG_SOURCE_ENABLE: cfg_ff.source_enable   <= pwdata[0];
            REG_SOURCE_XSHIFT: cfg_ff.source_x_shift  <= pwdata[11:0];
            REG_SOURCE_YSHIFT: cfg_ff.source_y_shift  <= pwdata[11:0];
            REG_SOURCE_WIDTH:  cfg_ff.source_width    <= pwdata[12:0];
            REG_SOURCE_HEIGHT: cfg_ff.source_height   <= pwdata[12:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_ROW_PITCH:     prdata = CSR_DBITS'(cfg_ff.row_pitch);
         REG_ACTIVE_X:      prdata = CSR_DBITS'(cfg_ff.active_x_offset);
         REG_ACTIVE_Y:      prdata = CSR_DBITS'(cfg_ff.active_y_offset);
         REG_SOURCE_ENABLE: prdata = CSR_DBITS'(cfg_ff.source_enable);
         REG_SOURCE_XSHIFT: prdata = CSR_DBITS'($unsigned(cfg_ff.source_x_shift));
         REG_SOURCE_YSHIFT: prdata = CSR_DBITS'($unsigned(cfg_ff.source_y_shift));
         REG_SOURCE_WIDTH:  prdata = CSR_DBITS'(cfg_ff.source_width);
         REG_SOURCE_HEIGHT: prdata = CSR_DBITS'(cfg_ff.source_height);
         default:           prdata = '0;
      endcase
   end

endmodule

>>> rtl/core/alsu_ctrl.sv
// ---------------------------------------------------------------------------
// Antialiased line stepper controller
// Sequences line set-up, slope division and the three step stages.
// ---------------------------------------------------------------------------
module alsu_ctrl
   import alsu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   input  logic       in_operation,
   output logic       in_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      in_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               if (in_operation == OP_START) begin
                  cmd.load_line = 1'b1;
                  state_in      = ST_DIVIDE;
               end else if (!status.steps_zero) begin
                  state_in = ST_LEVEL;
               end
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_LEVEL: begin
            cmd.level = 1'b1;
            state_in  = ST_SPLIT;
         end
         ST_SPLIT: begin
            cmd.split = 1'b1;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

>>> rtl/core/alsu_dp.sv
// ---------------------------------------------------------------------------
// Antialiased line stepper datapath
// Line set-up, serial slope divider, stepping state and pixel levels.
// ---------------------------------------------------------------------------
module alsu_dp
   import alsu_pkg::*;
#(
   parameter int FRACTION_BITS = 24,
   parameter int ADDRESS_BITS  = 22,
   parameter int COORD_BITS    = 12
) (
   input  logic                         clock,
   input  logic                         reset,
   input  cmd_type                      cmd,
   output status_type                   status,
   input  cfg_type                      cfg,
   input  logic signed [COORD_BITS-1:0] start_x,
   input  logic signed [COORD_BITS-1:0] start_y,
   input  logic signed [COORD_BITS-1:0] end_x,
   input  logic signed [COORD_BITS-1:0] end_y,
   input  logic [15:0]                  line_color,
   alsu_rsp_if.source                   rsp
);

   localparam int F    = FRACTION_BITS;
   localparam int A    = ADDRESS_BITS;
   localparam int CW   = COORD_BITS + 1;
   localparam int MW   = COORD_BITS + 1;
   localparam int RW   = MW + 1;
   localparam int BW   = (COORD_BITS > 12) ? COORD_BITS : 12;
   localparam int XW   = BW + 2;
   localparam int SW   = BW + 1;
   localparam int PW   = XW + 14;
   localparam int QW   = F + 1;
   localparam int AW   = F + 2;
   localparam int LS   = F - 8;
   localparam int VW   = AW - LS;
   localparam int CNTW = $clog2(F);
   localparam logic signed [AW-1:0] FRAC_ONE = {2'b01, {F{1'b0}}};

   // Line set-up
   logic signed [CW-1:0] dx, dy;
   logic [MW-1:0]        adx, ady, num, den;
   logic                 x_major, maj_neg, min_neg, qint;
   logic signed [13:0]   pitch_s, step_one, step_pitch, maj_unit, min_unit;
   logic signed [XW-1:0] xs, ys;
   logic signed [PW-1:0] prod;

   always_comb begin
      dx       = CW'(end_x) - CW'(start_x);
      dy       = CW'(end_y) - CW'(start_y);
      adx      = dx[CW-1] ? MW'(-dx) : MW'(dx);
      ady      = dy[CW-1] ? MW'(-dy) : MW'(dy);
      x_major  = adx > ady;
      num      = x_major ? ady : adx;
      den      = x_major ? adx : ady;
      maj_neg  = x_major ? dx[CW-1] : dy[CW-1];
      min_neg  = x_major ? dy[CW-1] : dx[CW-1];
      qint     = (den != '0) && (num >= den);
      pitch_s  = $signed({1'b0, cfg.row_pitch});
      step_one = 14'sd1;
      step_pitch = pitch_s;
      maj_unit = maj_neg ? -step_one : step_one;
      min_unit = min_neg ? -step_one : step_one;
      xs       = XW'(start_x) + XW'($signed({1'b0, cfg.active_x_offset}));
      ys       = XW'(start_y) + XW'($signed({1'b0, cfg.active_y_offset}));
      prod     = ys * pitch_s;
   end

   // Line state
   logic [A-1:0]          addr_ff, major_ff, minor_ff, side_ff;
   logic signed [AW-1:0]  acc_ff;
   logic [QW-1:0]         quot_ff;
   logic [RW-1:0]         rem_ff;
   logic [MW-1:0]         den_ff;
   logic                  div_zero_ff, neg_ff, x_major_ff, maj_neg_ff, min_neg_ff;
   logic [CNTW-1:0]       cnt_ff;
   logic [MW-1:0]         steps_ff;
   logic signed [SRC_BITS-1:0] sx_ff, sy_ff;
   logic [15:0]           color_ff;

   // Divider iteration
   logic [RW-1:0] rem2;
   logic          qbit;

   assign rem2 = {rem_ff[RW-2:0], 1'b0};
   assign qbit = !div_zero_ff && (rem2 >= RW'(den_ff));

   // Step update
   logic signed [AW-1:0] slope, sum, acc_in, acc_abs;
   logic                 carry_up, carry_dn, carry;
   logic signed [SRC_BITS-1:0] dmaj, dmin;
   logic [VW-1:0]        mag;
   logic [7:0]           mag8, center, lrem, sp;
   logic signed [VW-1:0] qv;
   logic [VW-1:0]        qoff;
   logic                 src_ok;

   always_comb begin
      slope = AW'(quot_ff);
      if (neg_ff) begin
         slope = -slope;
      end
      sum      = acc_ff + slope;
      carry_up = sum >= FRAC_ONE;
      carry_dn = sum <= -FRAC_ONE;
      carry    = carry_up || carry_dn;
      acc_in   = carry_up ? sum - FRAC_ONE : (carry_dn ? sum + FRAC_ONE : sum);
      dmaj     = maj_neg_ff ? -SRC_BITS'(1) : SRC_BITS'(1);
      dmin     = carry ? (min_neg_ff ? -SRC_BITS'(1) : SRC_BITS'(1)) : '0;
      acc_abs  = acc_ff[AW-1] ? -acc_ff : acc_ff;
      mag      = VW'(acc_abs >>> LS);
      mag8     = (mag > VW'(255)) ? 8'd255 : mag[7:0];
      center   = 8'((16'(8'd255 - mag8) * 16'd229) >> 8);
      lrem     = 8'd255 - center;
      qv       = VW'(acc_ff >>> LS);
      if (qv < -VW'(256)) begin
         qv = -VW'(256);
      end else if (qv > VW'(255)) begin
         qv = VW'(255);
      end
      qoff     = VW'(qv + VW'(256));
      sp       = qoff[8:1];
      src_ok   = cfg.source_enable && !sx_ff[SRC_BITS-1] && !sy_ff[SRC_BITS-1] &&
                 ($unsigned(sx_ff) < cfg.source_width) &&
                 ($unsigned(sy_ff) < cfg.source_height);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         steps_ff <= '0;
         acc_ff   <= '0;
         quot_ff  <= '0;
         cnt_ff   <= '0;
      end else if (cmd.load_line) begin
         steps_ff    <= x_major ? adx : ady;
         acc_ff      <= '0;
         quot_ff     <= QW'(qint);
         rem_ff      <= qint ? RW'(num - den) : RW'(num);
         den_ff      <= den;
         div_zero_ff <= den == '0;
         neg_ff      <= dx[CW-1] ^ dy[CW-1];
         cnt_ff      <= '0;
         x_major_ff  <= x_major;
         maj_neg_ff  <= maj_neg;
         min_neg_ff  <= min_neg;
         major_ff    <= x_major ? A'(maj_unit) : A'(maj_neg ? -step_pitch : step_pitch);
         side_ff     <= x_major ? A'(maj_neg ? -step_pitch : step_pitch) : A'(maj_unit);
         minor_ff    <= x_major ? A'(min_neg ? -step_pitch : step_pitch) : A'(min_unit);
         addr_ff     <= A'(PW'(xs) + prod);
         sx_ff       <= SRC_BITS'(SW'(start_x) - SW'(cfg.source_x_shift));
         sy_ff       <= SRC_BITS'(SW'(start_y) - SW'(cfg.source_y_shift));
         color_ff    <= line_color;
      end else if (cmd.div_step) begin
         rem_ff  <= qbit ? rem2 - RW'(den_ff) : rem2;
         quot_ff <= {quot_ff[QW-2:0], qbit};
         cnt_ff  <= cnt_ff + CNTW'(1);
      end else if (cmd.level) begin
         acc_ff   <= acc_in;
         addr_ff  <= addr_ff + (carry ? minor_ff : '0) + major_ff;
         sx_ff    <= sx_ff + (x_major_ff ? dmaj : dmin);
         sy_ff    <= sy_ff + (x_major_ff ? dmin : dmaj);
         steps_ff <= steps_ff - MW'(1);
      end
   end

   // Step stages and result register
   logic [A-1:0]  snap_addr_ff, snap_plus_ff, snap_minus_ff;
   logic signed [SRC_BITS-1:0] snap_sx_ff, snap_sy_ff;
   logic          snap_valid_ff, snap_last_ff;
   logic [7:0]    center_ff, lrem_ff, sp_ff, right_ff, left_ff;
   logic          out_valid_ff;

   always_ff @(posedge clock) begin
      if (cmd.level) begin
         snap_addr_ff  <= addr_ff;
         snap_plus_ff  <= addr_ff + side_ff;
         snap_minus_ff <= addr_ff - side_ff;
         snap_sx_ff    <= sx_ff;
         snap_sy_ff    <= sy_ff;
         snap_valid_ff <= src_ok;
         snap_last_ff  <= steps_ff == MW'(1);
         center_ff     <= center;
         lrem_ff       <= lrem;
         sp_ff         <= sp;
      end
      if (cmd.split) begin
         right_ff <= 8'((16'(lrem_ff) * 16'(sp_ff)) >> 8);
         left_ff  <= 8'((16'(lrem_ff) * 16'(8'd255 - sp_ff)) >> 8);
      end
      if (cmd.emit) begin
         rsp.center_address <= snap_addr_ff;
         rsp.center_level   <= center_ff;
         rsp.plus_address   <= snap_plus_ff;
         rsp.plus_level     <= CONE_ROM[right_ff];
         rsp.minus_address  <= snap_minus_ff;
         rsp.minus_level    <= CONE_ROM[left_ff];
         rsp.pixel_color    <= color_ff;
         rsp.source_x       <= snap_sx_ff;
         rsp.source_y       <= snap_sy_ff;
         rsp.source_valid   <= snap_valid_ff;
         rsp.last_step      <= snap_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign rsp.valid         = out_valid_ff;
   assign status.steps_zero = steps_ff == '0;
   assign status.div_last   = cnt_ff == CNTW'(F - 1);
   assign status.out_free   = !out_valid_ff || rsp.ready;

endmodule

>>> rtl/core/antialiased_line_stepper_unit.sv
// ---------------------------------------------------------------------------
// Antialiased line stepper
// Walks a line and gives a centre pixel and two side pixels per step item.
//
//   channel  direction  carries
//   req      in         start item (endpoints, colour) or step item
//   rsp      out        pixel triple, source coordinates, last-step flag
//   csr      in         APB-style register writes and reads
//
// A start item loads the line and then runs the serial slope divider.
// A step item runs through the level, split and cone table stages in order.
// A step with no steps left is accepted and gives no result.
// The result register lets the next item start while a result is stalled.
// Reset is synchronous and clears the line to zero steps.
// ---------------------------------------------------------------------------
module antialiased_line_stepper_unit
   import alsu_pkg::*;
#(
   parameter int FRACTION_BITS = 24,
   parameter int ADDRESS_BITS  = 22,
   parameter int COORD_BITS    = 12
) (
   input  logic                 clock,
   input  logic                 reset,
   alsu_req_if.sink             req,
   alsu_rsp_if.source           rsp,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [CSR_ABITS-1:0] csr_paddr,
   input  logic [CSR_DBITS-1:0] csr_pwdata,
   output logic [CSR_DBITS-1:0] csr_prdata,
   output logic                 csr_pready
);

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   alsu_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   alsu_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req.valid),
      .in_operation (req.operation),
      .in_ready     (req.ready),
      .status       (status),
      .cmd          (cmd)
   );

   alsu_dp #(
      .FRACTION_BITS (FRACTION_BITS),
      .ADDRESS_BITS  (ADDRESS_BITS),
      .COORD_BITS    (COORD_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .cfg        (cfg),
      .start_x    (req.start_x),
      .start_y    (req.start_y),
      .end_x      (req.end_x),
      .end_y      (req.end_y),
      .line_color (req.line_color),
      .rsp        (rsp)
   );

endmodule

>>> rtl/core/alsu_checker.sv
// ---------------------------------------------------------------------------
// Antialiased line stepper checker
// Port-level properties of the line stepper, bound to the top level.
// ---------------------------------------------------------------------------
`include "antialiased_line_stepper_unit_defines.svh"

module alsu_checker
   import alsu_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       req_operation,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_center_level,
   input logic       csr_pready
);

   `ALSU_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "stalled item dropped")
   `ALSU_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp_center_level), "stalled item changed")
   `ALSU_ASSERT_NEXT(a_start_busy, req_valid && req_ready && req_operation == OP_START, !req_ready, "start item did not begin division")
   `ALSU_ASSERT_NEXT(a_no_early_rsp, req_valid && req_ready, !$rose(rsp_valid), "result item too early")
   `ALSU_ASSERT_NOW(a_pready, 1'b1, csr_pready, "register port not ready")

endmodule

bind antialiased_line_stepper_unit alsu_checker u_alsu_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req.valid),
   .req_ready        (req.ready),
   .req_operation    (req.operation),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .rsp_center_level (rsp.center_level),
   .csr_pready       (csr_pready)
);
